/* hw/rtl/blinking_led_event_tracker_defines.svh */
// assertion macros for the blinking led event tracker
// no dependencies; included by files that carry assertions
`ifndef BLINKING_LED_EVENT_TRACKER_DEFINES_SVH
`define BLINKING_LED_EVENT_TRACKER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define BLT_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, quiet during reset
`define BLT_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hw/rtl/blt_pkg.sv */
// shared types, constants and helper functions of the blinking led event tracker
// no dependencies
package blt_pkg;

  localparam int SENSOR_SIZE = 128;
  localparam int COORD_W     = $clog2(SENSOR_SIZE);
  localparam int STAMP_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int MAP_DEPTH   = SENSOR_SIZE * SENSOR_SIZE;
  localparam int MAP_AW      = $clog2(MAP_DEPTH);
  localparam int POS_W       = COORD_W + FRAC_BITS;
  localparam int WGT_W       = FRAC_BITS + 1;
  localparam int PROD_W      = WGT_W + POS_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int RECIP6      = 43691;

  localparam logic [WGT_W-1:0] ONE_F       = WGT_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0] POS_MAX     = POS_W'(127) << FRAC_BITS;
  localparam logic [POS_W-1:0] POS_X_RESET = POS_W'(64) << FRAC_BITS;
  localparam logic [POS_W-1:0] POS_Y_RESET = POS_W'(35) << FRAC_BITS;

  localparam logic [15:0] PERIOD_RESET    = 16'd1000;
  localparam logic [7:0]  JITTER_RESET    = 8'd5;
  localparam logic [16:0] GAIN_RESET      = 17'd52429;
  localparam logic [16:0] THRESH_RESET    = 17'd45875;
  localparam logic [3:0]  RELATCH_RESET   = 4'd10;
  localparam logic [7:0]  MIN_MATCH_RESET = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE_ENABLE,
    CFG_BLINK_PERIOD,
    CFG_GAP_TOLERANCE,
    CFG_BLEND_GAIN,
    CFG_MATCH_THRESHOLD,
    CFG_RELATCH_INTERVAL,
    CFG_MIN_MATCHES
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GAP, ST_DIV,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9, ST_M10
  } state_t;

  typedef struct packed {
    logic        start;
    logic [7:0]  dividend;
    logic [15:0] divisor;
  } div_req_t;

  function automatic logic [WGT_W-1:0] dist_weight(input logic [COORD_W-1:0] coord,
                                                   input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] c;
    logic [POS_W-1:0] d;
    c = {coord, FRAC_BITS'(0)};
    d = (c >= pos) ? c - pos : pos - c;
    return ONE_F - WGT_W'(d >> 7);
  endfunction

  function automatic logic signed [15:0] x_speed(input logic [7:0] x);
    int xi;
    int n;
    int r;
    logic [31:0] qm;
    xi = int'(x);
    qm = '0;
    if (xi <= 20) begin
      r = (xi - 40) * 256;
    end else if (xi <= 50) begin
      r = xi * 128 - 30 * 256;
    end else if (xi <= 80) begin
      n  = 512 * xi - 21277;
      qm = 32'(n) * 32'(RECIP6);
      r  = int'(qm >> 18) - 2000;
    end else if (xi <= 110) begin
      r = xi * 128 - 35 * 256;
    end else if (xi <= 130) begin
      r = (xi - 90) * 256;
    end else begin
      r = 40 * 256;
    end
    return signed'(16'(r));
  endfunction

  function automatic logic signed [15:0] y_speed(input logic [COORD_W-1:0] y);
    int yi;
    int r;
    yi = int'(y);
    if (yi <= 20) begin
      r = -60 * 256;
    end else if (yi <= 30) begin
      r = yi * 1408 - 170 * 256;
    end else if (yi <= 40) begin
      r = (yi - 35) * 256;
    end else if (yi <= 50) begin
      r = yi * 1408 - 215 * 256;
    end else begin
      r = 60 * 256;
    end
    return signed'(16'(r));
  endfunction

endpackage

/* hw/rtl/blt_if.sv */
// event, result and configuration channels of the blinking led event tracker
// depends on blt_pkg
interface blt_event_if import blt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [COORD_W-1:0]     ev_x;
  logic [COORD_W-1:0]     ev_y;
  logic                   polarity;
  logic [STAMP_WIDTH-1:0] stamp;
  modport source (output valid, mode, ev_x, ev_y, polarity, stamp, input ready);
  modport sink (input valid, mode, ev_x, ev_y, polarity, stamp, output ready);
endinterface

interface blt_result_if import blt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  track_x;
  logic [COORD_W-1:0]  track_y;
  logic                motor_valid;
  logic signed [15:0]  motor0_speed;
  logic signed [15:0]  motor1_speed;
  modport source (output valid, track_x, track_y, motor_valid, motor0_speed, motor1_speed,
                  input ready);
  modport sink (input valid, track_x, track_y, motor_valid, motor0_speed, motor1_speed,
                output ready);
endinterface

interface blt_cfg_if import blt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/blinking_led_event_tracker.sv */
// top level of the blinking led event tracker: sequencer, tracker state, tick results
// depends on blt_pkg, blt_if, blt_ram, blt_div and blinking_led_event_tracker_defines.svh
//
//  channel   dir  handshake      beat
//  events    in   valid/ready    mode, ev_x, ev_y, polarity, stamp
//  results   out  valid/ready    track_x, track_y, motor_valid, motor0_speed, motor1_speed
//  cfg       in   valid/ready    index, data (always ready)
//
// after reset the timestamp store is swept to zero, all 16384 entries, events held off
// a tick or a dropped event is handled in ST_IDLE; a timestamp miss also passes ST_GAP
// a matching event takes a ram read, the divider, nine products on a single shared
// 17 x 23 multiplier and a write-back; below threshold, no relatch due: ends after ST_M6
// every event, a tick too, waits while results are full and undrained, or outside ST_IDLE
`include "blinking_led_event_tracker_defines.svh"

module blinking_led_event_tracker import blt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  blt_event_if.sink   events,
  blt_result_if.source results,
  blt_cfg_if.sink     cfg
);

  // configuration
  logic        drive_enable;
  logic [15:0] blink_period;
  logic [7:0]  gap_tolerance;
  logic [16:0] blend_gain;
  logic [16:0] match_threshold;
  logic [3:0]  relatch_interval;
  logic [7:0]  min_matches;

  // tracker state
  state_t           state, state_next;
  logic [POS_W-1:0] pos_x, pos_y;
  logic             decimate_bit;
  logic [3:0]       relatch_count;
  logic [7:0]       match_count;
  logic [MAP_AW:0]  clr_cnt;
  logic             clr_done;

  // item in flight
  logic [COORD_W-1:0]     ex, ey;
  logic [STAMP_WIDTH-1:0] stamp_l;
  logic [7:0]             diff_l;
  logic                   diff_over;
  logic [4:0]             rel_work;
  logic [WGT_W-1:0]       wt, wx, wy;
  logic [PROD_W-1:0]      prod, acc;

  // datapath
  logic [WGT_W-1:0]       mul_a;
  logic [POS_W-1:0]       mul_b;
  logic [WGT_W-1:0]       gain;
  logic [15:0]            period;
  logic [STAMP_WIDTH-1:0] stored, delta, diff;
  logic                   is_match;
  logic [WGT_W-1:0]       prod_hi;
  logic                   skip;
  logic [PROD_W:0]        blend_sum;
  logic [PROD_W-FRAC_BITS:0] blend_r;
  logic [POS_W-1:0]       blend_pos;
  logic                   ram_we;
  logic [MAP_AW-1:0]      ram_waddr;
  logic [STAMP_WIDTH-1:0] ram_wdata;
  logic                   accept, res_free;
  div_req_t               div_req;
  logic                   div_done;
  logic [FRAC_BITS-1:0]   div_quot;
  logic [COORD_W-1:0]     tick_x, tick_y;
  logic signed [15:0]     vx, vy;
  logic                   drive;

  assign clr_done = clr_cnt[MAP_AW];
  assign res_free = !results.valid || results.ready;
  assign events.ready = (state == ST_IDLE) && clr_done && res_free;
  assign accept = events.valid && events.ready;
  assign cfg.ready = 1'b1;

  assign gain   = (blend_gain > 17'(ONE_F)) ? ONE_F : blend_gain;
  assign period = (blink_period == 16'd0) ? 16'd1 : blink_period;
  assign delta  = stamp_l - stored;
  assign diff   = (delta >= STAMP_WIDTH'(period)) ? delta - STAMP_WIDTH'(period)
                                                  : STAMP_WIDTH'(period) - delta;
  assign is_match = diff < STAMP_WIDTH'(gap_tolerance);
  assign prod_hi  = prod[FRAC_BITS +: WGT_W];
  assign skip     = (rel_work != 5'd0) && (prod_hi < match_threshold);

  assign blend_sum = {1'b0, acc} + {1'b0, prod};
  assign blend_r   = blend_sum[PROD_W:FRAC_BITS];
  assign blend_pos = (blend_r > (PROD_W - FRAC_BITS + 1)'(POS_MAX)) ? POS_MAX
                                                                    : blend_r[POS_W-1:0];

  assign tick_x = pos_x[POS_W-1:FRAC_BITS];
  assign tick_y = pos_y[POS_W-1:FRAC_BITS];
  assign vx     = x_speed({1'b0, tick_x} + 8'd1);
  assign vy     = y_speed(tick_y);
  assign drive  = drive_enable && (match_count > min_matches);

  assign div_req.start    = (state == ST_GAP) && is_match;
  assign div_req.dividend = diff[7:0];
  assign div_req.divisor  = period;

  blt_ram #(
    .WIDTH(STAMP_WIDTH),
    .DEPTH(MAP_DEPTH)
  ) u_stamp_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr({events.ev_y, events.ev_x}),
    .rdata(stored)
  );

  blt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .done(div_done),
    .quot(div_quot)
  );

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    ram_we     = 1'b0;
    ram_waddr  = {ey, ex};
    ram_wdata  = stamp_l;
    if (!clr_done) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt[MAP_AW-1:0];
      ram_wdata = '0;
    end
    unique case (state)
      ST_IDLE: begin
        if (accept && !events.mode && !events.polarity && decimate_bit) begin
          state_next = ST_GAP;
        end
      end
      ST_GAP: begin
        if (is_match) begin
          state_next = ST_DIV;
        end else begin
          ram_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_M1;
        end
      end
      ST_M1: begin
        mul_a = gain;
        mul_b = POS_W'(dist_weight(ey, pos_x));
        state_next = ST_M2;
      end
      ST_M2: begin
        mul_a = prod_hi;
        mul_b = POS_W'(wt);
        state_next = ST_M3;
      end
      ST_M3: begin
        mul_a = gain;
        mul_b = POS_W'(dist_weight(ex, pos_y));
        state_next = ST_M4;
      end
      ST_M4: begin
        mul_a = prod_hi;
        mul_b = POS_W'(wt);
        state_next = ST_M5;
      end
      ST_M5: begin
        mul_a = wt;
        mul_b = POS_W'(wx);
        state_next = ST_M6;
      end
      ST_M6: begin
        mul_a = ONE_F - wx;
        mul_b = pos_x;
        state_next = skip ? ST_IDLE : ST_M7;
      end
      ST_M7: begin
        mul_a = wx;
        mul_b = {ey, FRAC_BITS'(0)};
        state_next = ST_M8;
      end
      ST_M8: begin
        mul_a = ONE_F - wy;
        mul_b = pos_y;
        state_next = ST_M9;
      end
      ST_M9: begin
        mul_a = wy;
        mul_b = {ex, FRAC_BITS'(0)};
        state_next = ST_M10;
      end
      ST_M10: begin
        ram_we     = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      clr_cnt          <= '0;
      drive_enable     <= 1'b0;
      blink_period     <= PERIOD_RESET;
      gap_tolerance    <= JITTER_RESET;
      blend_gain       <= GAIN_RESET;
      match_threshold  <= THRESH_RESET;
      relatch_interval <= RELATCH_RESET;
      min_matches      <= MIN_MATCH_RESET;
      pos_x            <= POS_X_RESET;
      pos_y            <= POS_Y_RESET;
      decimate_bit     <= 1'b0;
      relatch_count    <= '0;
      match_count      <= '0;
      results.valid    <= 1'b0;
    end else begin
      state <= state_next;
      prod  <= mul_a * mul_b;
      if (!clr_done) begin
        clr_cnt <= clr_cnt + (MAP_AW + 1)'(1);
      end

      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_DRIVE_ENABLE:     drive_enable     <= cfg.data[0];
          CFG_BLINK_PERIOD:     blink_period     <= cfg.data[15:0];
          CFG_GAP_TOLERANCE:    gap_tolerance    <= cfg.data[7:0];
          CFG_BLEND_GAIN:       blend_gain       <= cfg.data;
          CFG_MATCH_THRESHOLD:  match_threshold  <= cfg.data;
          CFG_RELATCH_INTERVAL: relatch_interval <= cfg.data[3:0];
          CFG_MIN_MATCHES:      min_matches      <= cfg.data[7:0];
          default: ;
        endcase
      end

      if (results.valid && results.ready && !(accept && events.mode)) begin
        results.valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept && events.mode) begin
            results.valid        <= 1'b1;
            results.track_x      <= tick_x;
            results.track_y      <= tick_y;
            results.motor_valid  <= drive;
            results.motor0_speed <= drive ? vx + vy : 16'sd0;
            results.motor1_speed <= drive ? vy - vx : 16'sd0;
            match_count          <= '0;
          end else if (accept && !events.polarity) begin
            decimate_bit <= !decimate_bit;
            ex      <= events.ev_x;
            ey      <= events.ev_y;
            stamp_l <= events.stamp;
          end
        end
        ST_GAP: begin
          diff_l    <= diff[7:0];
          diff_over <= diff >= STAMP_WIDTH'(period);
          rel_work  <= {1'b0, relatch_count} + 5'd1;
        end
        ST_DIV: begin
          if (relatch_interval == 4'd0) begin
            rel_work <= '0;
          end else if (rel_work >= {1'b0, relatch_interval}) begin
            rel_work <= rel_work - {1'b0, relatch_interval};
          end
          if (div_done) begin
            wt <= diff_over ? '0 : ONE_F - WGT_W'(div_quot);
          end
        end
        ST_M3:  wx <= prod_hi;
        ST_M5:  wy <= prod_hi;
        ST_M6:  relatch_count <= rel_work[3:0];
        ST_M7:  acc <= prod;
        ST_M8:  pos_x <= blend_pos;
        ST_M9:  acc <= prod;
        ST_M10: begin
          pos_y <= blend_pos;
          if (match_count != 8'hFF) begin
            match_count <= match_count + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // diff_l keeps the matched gap for debug visibility of the divider input
  `BLT_ASSERT_IMP(a_hold_while_clearing, clk, rst, !clr_done, !events.ready)
  `BLT_ASSERT_IMP(a_pos_in_range, clk, rst, 1'b1, (pos_x <= POS_MAX) && (pos_y <= POS_MAX))
  `BLT_ASSERT_IMP(a_ram_write_slot, clk, rst, ram_we,
    !clr_done || state == ST_GAP || state == ST_M10)
  `BLT_ASSERT_NXT(a_count_saturates, clk, rst, (match_count == 8'hFF) && (state != ST_IDLE),
    match_count == 8'hFF)
  `BLT_ASSERT_IMP(a_gap_diff_narrow, clk, rst, state == ST_DIV, diff_l < gap_tolerance)

endmodule

/* hw/rtl/blt_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module blt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/blt_div.sv */
// restoring divider, one quotient bit per cycle, fractional quotient of a/b with a < b
// depends on blt_pkg
module blt_div import blt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  div_req_t             req,
  output logic                 done,
  output logic [FRAC_BITS-1:0] quot
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [15:0]       rem;
  logic [15:0]       divisor;
  logic [16:0]       shifted;
  logic              fits;

  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= CNT_W'(FRAC_BITS);
        rem     <= {8'd0, req.dividend};
        divisor <= req.divisor;
      end else if (busy) begin
        cnt  <= cnt - CNT_W'(1);
        busy <= cnt != CNT_W'(1);
        rem  <= fits ? 16'(shifted - {1'b0, divisor}) : shifted[15:0];
        quot <= {quot[FRAC_BITS-2:0], fits};
      end
    end
  end

endmodule
